// ===== rtl/backlight_brightness_fader_core_macros.svh =====
// Assertion macros used by the checker file of the backlight fader, bbf_checker.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef BACKLIGHT_BRIGHTNESS_FADER_CORE_MACROS_SVH
`define BACKLIGHT_BRIGHTNESS_FADER_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BBF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("backlight fader assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("backlight fader assertion failed");

`endif

// ===== rtl/bbf_pkg.sv =====
// Package of the backlight brightness fader: command and register codes,
// level constants and the structs passed between modules. No dependencies.
package bbf_pkg;

  localparam logic [6:0] LevelMax   = 7'd100;
  localparam logic [6:0] KeyStep    = 7'd10;
  localparam logic [6:0] LadderBase = 7'd10;
  localparam logic [6:0] LevelReset = 7'd50;

  localparam logic [19:0] DdcPeriodReset = 20'd5000;
  localparam logic [19:0] KeyPeriodReset = 20'd20000;
  localparam logic [19:0] BusHoldReset   = 20'd20000;

  localparam int unsigned AddrWidth = 4;

  typedef enum logic [2:0] {
    CmdTick    = 3'd0,
    CmdDdc     = 3'd1,
    CmdPower   = 3'd2,
    CmdKeyDown = 3'd3,
    CmdKeyUp   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    RegDdcPeriod = 2'd0,
    RegKeyPeriod = 2'd1,
    RegBusHold   = 2'd2
  } reg_idx_e;

  localparam logic [7:0] PowerModeOn     = 8'd1;
  localparam logic [7:0] PowerModeOffLo  = 8'd2;
  localparam logic [7:0] PowerModeOffHi  = 8'd5;

  typedef struct packed {
    logic [19:0] ddc_period;
    logic [19:0] key_period;
    logic [19:0] bus_hold;
  } cfg_t;

  typedef struct packed {
    logic [6:0] pwm_percent;
    logic [6:0] target_percent;
    logic [6:0] reported_percent;
    logic       display_power_on;
    logic       bus_forced_off;
  } res_t;

endpackage

// ===== rtl/bbf_if.sv =====
// Valid/ready channel interfaces for the fader's event input and result output.
// Depends on nothing.
interface bbf_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] value;
  logic       bus_both_low;

  modport source (output valid, output command, output value, output bus_both_low,
                  input ready);
  modport sink   (input valid, input command, input value, input bus_both_low,
                  output ready);
endinterface

interface bbf_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] pwm_percent;
  logic [6:0] target_percent;
  logic [6:0] reported_percent;
  logic       display_power_on;
  logic       bus_forced_off;

  modport source (output valid, output pwm_percent, output target_percent,
                  output reported_percent, output display_power_on,
                  output bus_forced_off, input ready);
  modport sink   (input valid, input pwm_percent, input target_percent,
                  input reported_percent, input display_power_on,
                  input bus_forced_off, output ready);
endinterface

// ===== rtl/bbf_cfg.sv =====
// APB-style register block holding the fade periods and the bus-low hold time.
// Depends on bbf_pkg.
module bbf_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bbf_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output bbf_pkg::cfg_t                 cfg_o
);

  bbf_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        bbf_pkg::RegDdcPeriod: cfg_d.ddc_period = pwdata[19:0];
        bbf_pkg::RegKeyPeriod: cfg_d.key_period = pwdata[19:0];
        bbf_pkg::RegBusHold:   cfg_d.bus_hold   = pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      bbf_pkg::RegDdcPeriod: prdata = {12'd0, cfg_q.ddc_period};
      bbf_pkg::RegKeyPeriod: prdata = {12'd0, cfg_q.key_period};
      bbf_pkg::RegBusHold:   prdata = {12'd0, cfg_q.bus_hold};
      default:               prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ddc_period <= bbf_pkg::DdcPeriodReset;
      cfg_q.key_period <= bbf_pkg::KeyPeriodReset;
      cfg_q.bus_hold   <= bbf_pkg::BusHoldReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/bbf_engine.sv =====
// Fader state and its single-pass update for one event: fade stepping,
// bus-low force-off, DDC and power writes, and the key ladder. Depends on bbf_pkg.
module bbf_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic [2:0]    command_i,
  input  logic [7:0]    value_i,
  input  logic          bus_both_low_i,
  input  bbf_pkg::cfg_t cfg_i,
  output bbf_pkg::res_t res_o
);

  logic [6:0]  pwm_q, pwm_d;
  logic [6:0]  target_q, target_d;
  logic [6:0]  remembered_q, remembered_d;
  logic [6:0]  reported_q, reported_d;
  logic        power_q, power_d;
  logic        key_off_q, key_off_d;
  logic        slow_q, slow_d;
  logic [19:0] step_q, step_d;
  logic [19:0] low_cnt_q, low_cnt_d;
  logic        forced_q, forced_d;

  logic [19:0] period;
  logic [19:0] step_base;
  logic [19:0] step_inc;
  logic        hold_reached;
  logic        forced_tick;
  logic [6:0]  ladder_next;
  logic [6:0]  ddc_level;

  // Key ladder 0, 1, base, base+step, ... LevelMax.
  function automatic logic [6:0] ladder(input logic [6:0] cur, input logic down);
    logic [7:0] sum;
    sum = {1'b0, cur} + {1'b0, bbf_pkg::KeyStep};
    if (down) begin
      if (cur <= 7'd1) ladder = 7'd0;
      else if (cur <= bbf_pkg::LadderBase) ladder = 7'd1;
      else if ({1'b0, cur} < {1'b0, bbf_pkg::KeyStep} + {1'b0, bbf_pkg::LadderBase})
        ladder = bbf_pkg::LadderBase;
      else ladder = cur - bbf_pkg::KeyStep;
    end else begin
      if (cur == 7'd0) ladder = 7'd1;
      else if (cur < bbf_pkg::LadderBase) ladder = bbf_pkg::LadderBase;
      else if (sum > {1'b0, bbf_pkg::LevelMax}) ladder = bbf_pkg::LevelMax;
      else ladder = sum[6:0];
    end
  endfunction

  always_comb begin
    period = slow_q ? cfg_i.key_period : cfg_i.ddc_period;
    if (period == 20'd0) period = 20'd1;
  end

  assign hold_reached = (low_cnt_q >= cfg_i.bus_hold);
  // Forced state after this tick's bus sample.
  assign forced_tick  = bus_both_low_i && (forced_q || hold_reached);
  // Releasing the bus restarts the step counter before the fade of the same tick.
  assign step_base    = (!bus_both_low_i && forced_q) ? 20'd0 : step_q;
  assign step_inc     = step_base + 20'd1;
  assign ladder_next  = ladder(reported_q, command_i == bbf_pkg::CmdKeyDown);
  assign ddc_level    = (value_i > {1'b0, bbf_pkg::LevelMax}) ? bbf_pkg::LevelMax
                                                              : value_i[6:0];

  always_comb begin
    pwm_d        = pwm_q;
    target_d     = target_q;
    remembered_d = remembered_q;
    reported_d   = reported_q;
    power_d      = power_q;
    key_off_d    = key_off_q;
    slow_d       = slow_q;
    step_d       = step_q;
    low_cnt_d    = low_cnt_q;
    forced_d     = forced_q;

    unique case (command_i) inside
      bbf_pkg::CmdTick: begin
        forced_d = forced_tick;
        if (bus_both_low_i) begin
          if (!hold_reached) low_cnt_d = low_cnt_q + 20'd1;
          if (!forced_q && hold_reached) pwm_d = 7'd0;
        end else begin
          low_cnt_d = 20'd0;
        end
        if (!forced_tick) begin
          if (step_inc < period) begin
            step_d = step_inc;
          end else begin
            step_d = 20'd0;
            if (pwm_q < target_q) pwm_d = pwm_q + 7'd1;
            else if (pwm_q > target_q) pwm_d = pwm_q - 7'd1;
          end
        end else begin
          step_d = step_base;
        end
      end
      bbf_pkg::CmdDdc: begin
        reported_d = ddc_level;
        if (ddc_level != 7'd0) begin
          remembered_d = ddc_level;
          key_off_d    = 1'b0;
        end
        target_d = power_q ? ddc_level : 7'd0;
        slow_d   = 1'b0;
        step_d   = 20'd0;
      end
      bbf_pkg::CmdPower: begin
        if (value_i == bbf_pkg::PowerModeOn) begin
          if (!power_q) begin
            power_d  = 1'b1;
            target_d = key_off_q ? 7'd0 : remembered_q;
            slow_d   = 1'b0;
            step_d   = 20'd0;
          end
        end else if (value_i >= bbf_pkg::PowerModeOffLo &&
                     value_i <= bbf_pkg::PowerModeOffHi) begin
          power_d  = 1'b0;
          target_d = 7'd0;
          slow_d   = 1'b0;
          step_d   = 20'd0;
        end
      end
      bbf_pkg::CmdKeyDown, bbf_pkg::CmdKeyUp: begin
        if (ladder_next != reported_q) begin
          reported_d = ladder_next;
          step_d     = 20'd0;
          if (ladder_next == 7'd0) begin
            key_off_d = 1'b1;
            target_d  = 7'd0;
            slow_d    = 1'b1;
          end else begin
            key_off_d    = 1'b0;
            remembered_d = ladder_next;
            target_d     = power_q ? ladder_next : 7'd0;
            slow_d       = power_q;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_q        <= bbf_pkg::LevelReset;
      target_q     <= bbf_pkg::LevelReset;
      remembered_q <= bbf_pkg::LevelReset;
      reported_q   <= bbf_pkg::LevelReset;
      power_q      <= 1'b1;
      key_off_q    <= 1'b0;
      slow_q       <= 1'b0;
      step_q       <= 20'd0;
      low_cnt_q    <= 20'd0;
      forced_q     <= 1'b0;
    end else if (fire_i) begin
      pwm_q        <= pwm_d;
      target_q     <= target_d;
      remembered_q <= remembered_d;
      reported_q   <= reported_d;
      power_q      <= power_d;
      key_off_q    <= key_off_d;
      slow_q       <= slow_d;
      step_q       <= step_d;
      low_cnt_q    <= low_cnt_d;
      forced_q     <= forced_d;
    end
  end

  // The result of an event is the state it leaves behind.
  assign res_o.pwm_percent      = pwm_d;
  assign res_o.target_percent   = target_d;
  assign res_o.reported_percent = reported_d;
  assign res_o.display_power_on = power_d;
  assign res_o.bus_forced_off   = forced_d;

endmodule

// ===== rtl/backlight_brightness_fader_core.sv =====
// Backlight brightness fader, top level. An event passes through the input register
// and then the result register; either may hold it while the result channel stalls.
// Throughput: one event per cycle while the result channel is not stalled, set by the state update pass.
// Reset (rst_ni, asynchronous, active low) sets levels to 50, power on, counters
// and flags cleared, fade periods 5000/20000 and bus-low hold 20000 ticks.
// Depends on bbf_pkg, bbf_if, bbf_cfg and bbf_engine.
module backlight_brightness_fader_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bbf_in_if.sink                        in_ch_i,
  bbf_out_if.source                     out_ch_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bbf_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  bbf_pkg::cfg_t cfg;
  bbf_pkg::res_t res;
  bbf_pkg::res_t res_q;

  logic       s1_valid_q;
  logic [2:0] s1_cmd_q;
  logic [7:0] s1_value_q;
  logic       s1_low_q;
  logic       out_valid_q;
  logic       advance;
  logic       in_fire;

  bbf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bbf_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (advance),
    .command_i      (s1_cmd_q),
    .value_i        (s1_value_q),
    .bus_both_low_i (s1_low_q),
    .cfg_i          (cfg),
    .res_o          (res)
  );

  // The event in the input register moves on whenever the result slot is free.
  assign advance       = s1_valid_q && (!out_valid_q || out_ch_o.ready);
  assign in_ch_i.ready = !s1_valid_q || advance;
  assign in_fire       = in_ch_i.valid && in_ch_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) s1_valid_q <= 1'b1;
      else if (advance) s1_valid_q <= 1'b0;
      if (advance) out_valid_q <= 1'b1;
      else if (out_ch_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q   <= in_ch_i.command;
      s1_value_q <= in_ch_i.value;
      s1_low_q   <= in_ch_i.bus_both_low;
    end
    if (advance) res_q <= res;
  end

  assign out_ch_o.valid            = out_valid_q;
  assign out_ch_o.pwm_percent      = res_q.pwm_percent;
  assign out_ch_o.target_percent   = res_q.target_percent;
  assign out_ch_o.reported_percent = res_q.reported_percent;
  assign out_ch_o.display_power_on = res_q.display_power_on;
  assign out_ch_o.bus_forced_off   = res_q.bus_forced_off;

endmodule

// ===== rtl/bbf_checker.sv =====
// Port-level checks of the backlight fader's result channel, bound to the top.
// Depends on bbf_pkg and backlight_brightness_fader_core_macros.svh.
`include "backlight_brightness_fader_core_macros.svh"

module bbf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [6:0] pwm_percent_i,
  input logic [6:0] target_percent_i,
  input logic [6:0] reported_percent_i,
  input logic       bus_forced_off_i
);

  // A stalled result transaction stays offered.
  `BBF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // While the bus forces the backlight off, the duty is zero.
  `BBF_ASSERT_IMPL(a_forced_dark, clk_i, rst_ni, out_valid_i && bus_forced_off_i, pwm_percent_i == 7'd0)

  // Levels never leave the clamp range.
  `BBF_ASSERT_IMPL(a_pwm_range, clk_i, rst_ni, out_valid_i, pwm_percent_i <= bbf_pkg::LevelMax)

  `BBF_ASSERT_IMPL(a_levels_range, clk_i, rst_ni, out_valid_i, (target_percent_i <= bbf_pkg::LevelMax) && (reported_percent_i <= bbf_pkg::LevelMax))

endmodule

bind backlight_brightness_fader_core bbf_checker u_bbf_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_ch_o.valid),
  .out_ready_i        (out_ch_o.ready),
  .pwm_percent_i      (out_ch_o.pwm_percent),
  .target_percent_i   (out_ch_o.target_percent),
  .reported_percent_i (out_ch_o.reported_percent),
  .bus_forced_off_i   (out_ch_o.bus_forced_off)
);
